// ===== hdl/dss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dss_pkg;

   localparam int TRACK_W = 16;
   localparam int DIST_W  = 16;
   localparam int SUM_W   = 20;
   localparam int KEY_W   = TRACK_W + 1;
   localparam int RSP_W   = 56;

   typedef enum logic [1:0] {
      MODE_FIFO  = 2'd0,
      MODE_SSTF  = 2'd1,
      MODE_SCAN  = 2'd2,
      MODE_CSCAN = 2'd3
   } mode_type;

   typedef logic [0:0] reg_index_type;
   localparam reg_index_type REG_MODE  = 1'b0;
   localparam reg_index_type REG_START = 1'b1;

   typedef struct packed {
      logic clear;
      logic sample;
   } sel_ctrl_type;

endpackage

`default_nettype wire

// ===== hdl/dss_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dss_store #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [AW-1:0]               wr_addr,
   input  wire logic [dss_pkg::TRACK_W-1:0] wr_data,
   input  wire logic                        rd_en,
   input  wire logic [AW-1:0]               rd_addr,
   output logic      [dss_pkg::TRACK_W-1:0] rd_data
);

   logic [dss_pkg::TRACK_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/dss_sel.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dss_sel #(
   parameter int AW = 4
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire dss_pkg::sel_ctrl_type       ctrl,
   input  wire dss_pkg::mode_type           mode,
   input  wire logic [dss_pkg::TRACK_W-1:0] start_track,
   input  wire logic [dss_pkg::TRACK_W-1:0] head_track,
   input  wire logic [dss_pkg::TRACK_W-1:0] entry_track,
   input  wire logic [AW-1:0]               entry_idx,
   output logic      [dss_pkg::TRACK_W-1:0] best_track,
   output logic      [AW-1:0]               best_idx,
   output logic                             best_found
);

   logic [dss_pkg::KEY_W-1:0]   key;
   logic [dss_pkg::KEY_W-1:0]   best_key_ff, best_key_in;
   logic [dss_pkg::TRACK_W-1:0] best_track_ff, best_track_in;
   logic [AW-1:0]               best_idx_ff, best_idx_in;
   logic                        found_ff, found_in;
   logic                        at_or_below;
   logic [dss_pkg::TRACK_W-1:0] span;

   // ordering key: smallest key is served next, strict compare keeps earliest arrival
   always_comb begin
      at_or_below = (entry_track <= start_track);
      span = (head_track > entry_track) ? (head_track - entry_track)
                                        : (entry_track - head_track);
      case (mode)
         dss_pkg::MODE_FIFO:  key = '0;
         dss_pkg::MODE_SSTF:  key = {1'b0, span};
         // upward pass ascending, then downward pass descending
         dss_pkg::MODE_SCAN:  key = {at_or_below, at_or_below ? ~entry_track : entry_track};
         dss_pkg::MODE_CSCAN: key = {at_or_below, entry_track};
         default:             key = '0;
      endcase
   end

   always_comb begin
      best_key_in   = best_key_ff;
      best_track_in = best_track_ff;
      best_idx_in   = best_idx_ff;
      found_in      = found_ff;
      if (ctrl.clear) begin
         found_in = 1'b0;
      end else if (ctrl.sample && (!found_ff || key < best_key_ff)) begin
         found_in      = 1'b1;
         best_key_in   = key;
         best_track_in = entry_track;
         best_idx_in   = entry_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      best_key_ff   <= best_key_in;
      best_track_ff <= best_track_in;
      best_idx_ff   <= best_idx_in;
   end

   assign best_track = best_track_ff;
   assign best_idx   = best_idx_ff;
   assign best_found = found_ff;

endmodule

`default_nettype wire

// ===== hdl/disk_seek_request_scheduler_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Disk seek scheduler: requests stream in one per cycle and are queued (up to QUEUE_DEPTH;
// extras are dropped and every result of that batch reports dropped). The request with
// tlast closes the batch; the block then stops accepting and emits one result per queued
// request in FIFO, SSTF, SCAN or C-SCAN order, starting from start_track. Each result is
// picked by walking the whole queue through one shared compare unit, one entry read from
// the request memory per cycle; the next request is taken only after the whole batch has
// been emitted.
// Configuration may only be written while the block waits for requests.
module disk_seek_request_scheduler_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [15:0]  req_tdata,   // [15:0] track
   input  wire logic         req_tlast,   // last_request
   // result channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic      [55:0]  rsp_tdata,   // [15:0] served_track, [31:16] seek_distance,
                                          // [51:32] total_seek, [55:52] zero
   output logic              rsp_tuser,   // dropped
   output logic              rsp_tlast,   // last_result
   // configuration
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [0:0]   csr_index,
   input  wire logic [15:0]  csr_data
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type                   state_ff, state_in;
   dss_pkg::mode_type           mode_ff, mode_in;
   logic [dss_pkg::TRACK_W-1:0] start_ff, start_in;
   logic [CW-1:0]               count_ff, count_in;
   logic                        ovf_ff, ovf_in;
   logic [dss_pkg::TRACK_W-1:0] head_ff, head_in;
   logic [dss_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [CW-1:0]               served_ff, served_in;
   logic [CW-1:0]               rd_ptr_ff, rd_ptr_in;
   logic                        rd_vld_ff, rd_vld_in;
   logic [AW-1:0]               rd_idx_ff, rd_idx_in;
   logic [QUEUE_DEPTH-1:0]      visited_ff, visited_in;

   logic [dss_pkg::TRACK_W-1:0] rsp_track_ff, rsp_track_in;
   logic [dss_pkg::DIST_W-1:0]  rsp_dist_ff, rsp_dist_in;
   logic [dss_pkg::SUM_W-1:0]   rsp_sum_ff, rsp_sum_in;
   logic                        rsp_drop_ff, rsp_drop_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        req_xfer, rsp_xfer, csr_xfer;
   logic                        store_wr, issue, scan_done;
   logic [dss_pkg::TRACK_W-1:0] rd_data;
   logic [dss_pkg::TRACK_W-1:0] best_track;
   logic [AW-1:0]               best_idx;
   logic                        best_found;
   logic [dss_pkg::DIST_W-1:0]  seek_dist;
   dss_pkg::sel_ctrl_type       sel_ctrl;

   assign req_tready = (state_ff == ST_LOAD);
   assign csr_ready  = 1'b1;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign csr_xfer   = csr_valid && csr_ready;

   assign store_wr   = req_xfer && (count_ff < DEPTH_C);
   assign issue      = (state_ff == ST_SCAN) && (rd_ptr_ff < count_ff);
   assign scan_done  = (state_ff == ST_SCAN) && !issue && !rd_vld_ff;

   assign sel_ctrl.clear  = (state_ff != ST_SCAN);
   assign sel_ctrl.sample = rd_vld_ff && !visited_ff[rd_idx_ff];

   assign seek_dist = (head_ff > best_track) ? (head_ff - best_track)
                                             : (best_track - head_ff);

   dss_store #(
      .DEPTH (QUEUE_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_en   (issue),
      .rd_addr (rd_ptr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   dss_sel #(
      .AW (AW)
   ) u_sel (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (sel_ctrl),
      .mode        (mode_ff),
      .start_track (start_ff),
      .head_track  (head_ff),
      .entry_track (rd_data),
      .entry_idx   (rd_idx_ff),
      .best_track  (best_track),
      .best_idx    (best_idx),
      .best_found  (best_found)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      start_in     = start_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      head_in      = head_ff;
      sum_in       = sum_ff;
      served_in    = served_ff;
      rd_ptr_in    = rd_ptr_ff;
      rd_vld_in    = issue;
      rd_idx_in    = rd_ptr_ff[AW-1:0];
      visited_in   = visited_ff;
      rsp_track_in = rsp_track_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_xfer) begin
         unique case (csr_index)
            dss_pkg::REG_MODE:  mode_in  = dss_pkg::mode_type'(csr_data[1:0]);
            dss_pkg::REG_START: start_in = csr_data;
            default:            ;
         endcase
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               if (store_wr) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in   = ST_SCAN;
                  head_in    = start_ff;
                  sum_in     = '0;
                  served_in  = '0;
                  rd_ptr_in  = '0;
                  visited_in = '0;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               rd_ptr_in = rd_ptr_ff + CW'(1);
            end
            if (scan_done) begin
               state_in             = ST_EMIT;
               rsp_track_in         = best_track;
               rsp_dist_in          = seek_dist;
               sum_in               = sum_ff + dss_pkg::SUM_W'(seek_dist);
               rsp_sum_in           = sum_ff + dss_pkg::SUM_W'(seek_dist);
               rsp_drop_in          = ovf_ff;
               rsp_last_in          = ((served_ff + CW'(1)) == count_ff);
               visited_in[best_idx] = 1'b1;
               head_in              = best_track;
               served_in            = served_ff + CW'(1);
            end
         end
         ST_EMIT: begin
            if (rsp_xfer) begin
               if (rsp_last_ff) begin
                  state_in = ST_LOAD;
                  count_in = '0;
                  ovf_in   = 1'b0;
               end else begin
                  state_in  = ST_SCAN;
                  rd_ptr_in = '0;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         mode_ff    <= dss_pkg::MODE_FIFO;
         start_ff   <= '0;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         head_ff    <= '0;
         sum_ff     <= '0;
         served_ff  <= '0;
         rd_ptr_ff  <= '0;
         rd_vld_ff  <= 1'b0;
         visited_ff <= '0;
      end else begin
         state_ff   <= state_in;
         mode_ff    <= mode_in;
         start_ff   <= start_in;
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
         head_ff    <= head_in;
         sum_ff     <= sum_in;
         served_ff  <= served_in;
         rd_ptr_ff  <= rd_ptr_in;
         rd_vld_ff  <= rd_vld_in;
         visited_ff <= visited_in;
      end
      rd_idx_ff    <= rd_idx_in;
      rsp_track_ff <= rsp_track_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_drop_ff  <= rsp_drop_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = {4'b0000, rsp_sum_ff, rsp_dist_ff, rsp_track_ff};
   assign rsp_tuser  = rsp_drop_ff;
   assign rsp_tlast  = rsp_last_ff;

   // a finished scan always has an unvisited entry to serve
   a_scan_found: assert property (@(posedge clock) disable iff (reset)
      scan_done |-> best_found)
      else $error("scan finished without a selected request");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("request count beyond queue depth");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("loading and emitting at once");

   a_batch_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_tlast) |=> (req_tready && count_ff == '0 && !ovf_ff))
      else $error("batch state not cleared after final result");

   a_served_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (served_ff <= count_ff && served_ff != '0))
      else $error("served count out of range");

endmodule

`default_nettype wire
